>>> hdl/ill_pkg.sv
// Shared types, codes and character helpers for the integer literal lexer.
`default_nettype none
package ill_pkg;

  // Lexer phase, one-hot.
  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0000000000001,
    PH_START  = 13'b0000000000010,
    PH_SIGN   = 13'b0000000000100,
    PH_ZERO   = 13'b0000000001000,
    PH_CFIRST = 13'b0000000010000,
    PH_CORE   = 13'b0000000100000,
    PH_ENTRY  = 13'b0000001000000,
    PH_U      = 13'b0000010000000,
    PH_UW     = 13'b0000100000000,
    PH_S      = 13'b0001000000000,
    PH_SW     = 13'b0010000000000,
    PH_L      = 13'b0100000000000,
    PH_P      = 13'b1000000000000
  } ill_phase_e;

  typedef enum logic [3:0] {
    TY_INT   = 4'd0,
    TY_LONG  = 4'd1,
    TY_DWORD = 4'd2,
    TY_QWORD = 4'd3,
    TY_BYTE  = 4'd4,
    TY_WORD  = 4'd5,
    TY_SMALL = 4'd6,
    TY_SHORT = 4'd7,
    TY_PTR   = 4'd8,
    TY_FRAC  = 4'd9
  } ill_type_e;

  typedef enum logic [2:0] {
    ERR_OK      = 3'd0,
    ERR_INVALID = 3'd1,
    ERR_BIG     = 3'd2,
    ERR_QWORD   = 3'd3,
    ERR_LONG    = 3'd4,
    ERR_UMINUS  = 3'd5
  } ill_err_e;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } ill_base_e;

  typedef struct packed {
    logic p;
    logic u;
    logic l;
  } ill_flags_t;

  typedef struct packed {
    ill_phase_e phase;
    logic [63:0] acc;
    ill_base_e   radix;
    logic        negative;
    logic [6:0]  width_suffix;
    ill_flags_t  flags;
    ill_err_e    first_error;
  } ill_state_t;

  typedef struct packed {
    logic [7:0]  length;
    ill_base_e   base_code;
    ill_err_e    error_code;
    ill_type_e   type_code;
    logic [63:0] value;
  } ill_result_t;

  // Character codes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_X_LC  = 8'h78;
  localparam logic [7:0] CH_X_UC  = 8'h58;
  localparam logic [7:0] CH_O_LC  = 8'h6F;
  localparam logic [7:0] CH_O_UC  = 8'h4F;
  localparam logic [7:0] CH_B_LC  = 8'h62;
  localparam logic [7:0] CH_B_UC  = 8'h42;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_P     = 8'h70;

  localparam logic [6:0] DIGIT_NONE = 7'd99;
  localparam logic [6:0] DIGIT_LIM  = 7'd36;

  // Range limits.
  localparam logic [63:0] TOP_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] I64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] U32_MAX  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] I32_MAX  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] I32_NMAX = 64'h0000_0000_8000_0000;
  localparam logic [63:0] U16_MAX  = 64'd65535;
  localparam logic [63:0] I16_MAX  = 64'd32767;
  localparam logic [63:0] U8_MAX   = 64'd255;
  localparam logic [63:0] I8_MAX   = 64'd127;

  function automatic logic [6:0] digit_of(input logic [7:0] c);
    logic [6:0] d;
    d = DIGIT_NONE;
    if (c >= CH_0 && c <= CH_9) d = 7'(c - CH_0);
    else if (c >= CH_LA && c <= CH_LZ) d = 7'(c - CH_LA) + 7'd10;
    else if (c >= CH_UA && c <= CH_UZ) d = 7'(c - CH_UA) + 7'd10;
    return d;
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return digit_of(c) < DIGIT_LIM;
  endfunction

  function automatic ill_err_e note_err(input ill_err_e cur, input ill_err_e e);
    return (cur == ERR_OK) ? e : cur;
  endfunction

endpackage
`default_nettype wire

>>> hdl/ill_in_reg.sv
// Input register stage holding one character transaction for the lexer.
`default_nettype none
module ill_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       start_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      ch_o,
  output logic            start_o
);

  logic       valid_q, valid_d;
  logic [7:0] ch_q;
  logic       start_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = valid_i ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ch_q    <= ch_i;
      start_q <= start_i;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign start_o = start_q;

endmodule
`default_nettype wire

>>> hdl/ill_step.sv
// Combinational next-state and result logic for one character of a literal.
`default_nettype none
module ill_step #(
  parameter int unsigned LEN_BITS = 8
) (
  input  wire ill_pkg::ill_state_t state_i,
  input  wire logic [LEN_BITS-1:0] count_i,
  input  wire logic [7:0]      ch_i,
  input  wire logic            start_i,
  output ill_pkg::ill_state_t  state_o,
  output logic [LEN_BITS-1:0]  count_o,
  output logic                 emit_o,
  output ill_pkg::ill_result_t result_o
);
  import ill_pkg::*;

  localparam int unsigned CW = (LEN_BITS > 8) ? LEN_BITS : 8;
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
  localparam logic [6:0] WS_SAT = 7'd127;

  function automatic logic [LEN_BITS-1:0] bump(input logic [LEN_BITS-1:0] v);
    return (v != LEN_MAX) ? v + LEN_BITS'(1) : v;
  endfunction

  function automatic logic [4:0] base_of(input ill_base_e r);
    logic [4:0] b;
    unique case (r)
      BASE_BIN: b = 5'd2;
      BASE_OCT: b = 5'd8;
      BASE_DEC: b = 5'd10;
      BASE_HEX: b = 5'd16;
      default:  b = 5'd10;
    endcase
    return b;
  endfunction

  ill_state_t        st;
  logic [LEN_BITS-1:0] cnt;
  logic              done;
  logic              fin;
  logic              emit;
  ill_type_e         ty;
  logic [6:0]        d;
  logic [4:0]        b;
  logic [67:0]       prod;
  logic [67:0]       sum;
  logic [10:0]       ws_next;
  logic              needs_ul;
  logic              uns;
  logic [CW-1:0]     cnt_ext;

  always_comb begin
    st   = state_i;
    cnt  = count_i;
    done = 1'b0;
    fin  = 1'b0;
    emit = 1'b0;
    ty   = TY_INT;
    uns  = 1'b0;
    d    = digit_of(ch_i);

    if (start_i) begin
      st.phase        = PH_START;
      st.acc          = '0;
      st.radix        = BASE_DEC;
      st.negative     = 1'b0;
      st.width_suffix = '0;
      st.flags        = '0;
      st.first_error  = ERR_OK;
      cnt             = '0;
    end

    b        = base_of(st.radix);
    needs_ul = st.acc[63] && (st.acc != TOP_BIT);

    unique case (st.radix)
      BASE_BIN: prod = {4'b0, st.acc} << 1;
      BASE_OCT: prod = {4'b0, st.acc} << 3;
      BASE_HEX: prod = {4'b0, st.acc} << 4;
      default:  prod = ({4'b0, st.acc} << 3) + ({4'b0, st.acc} << 1);
    endcase
    sum     = prod + 68'(d);
    ws_next = 11'(st.width_suffix) * 11'd10 + 11'(d);

    // Optional sign.
    if (st.phase == PH_START) begin
      if (ch_i == CH_MINUS || ch_i == CH_PLUS) begin
        st.negative = (ch_i == CH_MINUS);
        cnt         = bump(cnt);
        done        = 1'b1;
      end
      st.phase = PH_SIGN;
    end

    // Leading zero that may open a prefix.
    if (!done && st.phase == PH_SIGN) begin
      if (ch_i == CH_0) begin
        cnt      = bump(cnt);
        st.phase = PH_ZERO;
        done     = 1'b1;
      end else begin
        st.phase = PH_CFIRST;
      end
    end

    if (!done && st.phase == PH_ZERO) begin
      if (ch_i == CH_X_LC || ch_i == CH_X_UC || ch_i == CH_O_LC || ch_i == CH_O_UC ||
          ch_i == CH_B_LC || ch_i == CH_B_UC) begin
        if (ch_i == CH_X_LC || ch_i == CH_X_UC) st.radix = BASE_HEX;
        else if (ch_i == CH_O_LC || ch_i == CH_O_UC) st.radix = BASE_OCT;
        else st.radix = BASE_BIN;
        cnt      = bump(cnt);
        st.phase = PH_CFIRST;
        done     = 1'b1;
      end else if (is_alnum(ch_i) && ch_i != CH_U && ch_i != CH_S && ch_i != CH_L &&
                   ch_i != CH_P) begin
        st.first_error = note_err(st.first_error, ERR_INVALID);
        ty   = TY_INT;
        emit = 1'b1;
        done = 1'b1;
      end else if (ch_i == CH_DOT) begin
        ty   = TY_FRAC;
        emit = 1'b1;
        done = 1'b1;
      end else begin
        st.phase = PH_ENTRY;
      end
    end

    // Digits of the number, with separators skipped.
    if (!done && (st.phase == PH_CFIRST || st.phase == PH_CORE)) begin
      if (st.phase == PH_CFIRST && d >= 7'(b)) begin
        st.first_error = note_err(st.first_error, ERR_INVALID);
      end
      st.phase = PH_CORE;
      if (ch_i == CH_QUOTE) begin
        cnt  = bump(cnt);
        done = 1'b1;
      end else if (d < 7'(b)) begin
        if (sum[67:64] != 4'd0) st.first_error = note_err(st.first_error, ERR_BIG);
        st.acc = sum[63:0];
        cnt    = bump(cnt);
        done   = 1'b1;
      end else begin
        st.phase = PH_ENTRY;
      end
    end

    // First character after the digits: suffix or end.
    if (!done && st.phase == PH_ENTRY) begin
      done = 1'b1;
      if (ch_i == CH_U) begin
        st.flags.u = 1'b1;
        cnt        = bump(cnt);
        st.phase   = PH_U;
      end else begin
        if (needs_ul) st.first_error = note_err(st.first_error, ERR_QWORD);
        if (ch_i == CH_DOT && st.radix == BASE_DEC) begin
          ty   = TY_FRAC;
          emit = 1'b1;
        end else begin
          if (st.negative && st.acc > TOP_BIT) begin
            st.first_error = note_err(st.first_error, ERR_BIG);
          end
          if (ch_i == CH_L) begin
            st.flags.l = 1'b1;
            cnt        = bump(cnt);
            st.phase   = PH_L;
          end else if (ch_i == CH_S) begin
            cnt      = bump(cnt);
            st.phase = PH_S;
          end else if (ch_i == CH_P) begin
            st.flags.p = 1'b1;
            cnt        = bump(cnt);
            st.phase   = PH_P;
          end else begin
            ty  = TY_INT;
            fin = 1'b1;
          end
        end
      end
    end

    if (!done && st.phase == PH_U) begin
      done = 1'b1;
      if (ch_i != CH_L && needs_ul) st.first_error = note_err(st.first_error, ERR_QWORD);
      if (st.negative && st.acc > TOP_BIT) begin
        st.first_error = note_err(st.first_error, ERR_BIG);
      end
      if (ch_i == CH_L) begin
        st.flags.l = 1'b1;
        cnt        = bump(cnt);
        st.phase   = PH_L;
      end else if (is_dec(ch_i)) begin
        st.width_suffix = d;
        cnt             = bump(cnt);
        st.phase        = PH_UW;
      end else begin
        if (is_alnum(ch_i)) st.first_error = note_err(st.first_error, ERR_INVALID);
        ty  = TY_DWORD;
        fin = 1'b1;
      end
    end

    if (!done && st.phase == PH_S) begin
      done = 1'b1;
      if (ch_i == CH_L) begin
        st.flags.l = 1'b1;
        cnt        = bump(cnt);
        st.phase   = PH_L;
      end else if (is_dec(ch_i)) begin
        st.width_suffix = d;
        cnt             = bump(cnt);
        st.phase        = PH_SW;
      end else begin
        if (is_alnum(ch_i)) st.first_error = note_err(st.first_error, ERR_INVALID);
        ty  = TY_INT;
        fin = 1'b1;
      end
    end

    // Width digits after u or s.
    if (!done && (st.phase == PH_UW || st.phase == PH_SW)) begin
      done = 1'b1;
      uns  = (st.phase == PH_UW);
      if (is_dec(ch_i)) begin
        st.width_suffix = (ws_next > 11'(WS_SAT)) ? WS_SAT : ws_next[6:0];
        cnt             = bump(cnt);
      end else begin
        fin = 1'b1;
        if (st.width_suffix == 7'd8) begin
          if (uns ? (st.acc > U8_MAX)
                  : (st.acc > I8_MAX + 64'(st.negative))) begin
            st.first_error = note_err(st.first_error, ERR_BIG);
          end
          ty = uns ? TY_BYTE : TY_SMALL;
        end else if (st.width_suffix == 7'd16) begin
          if (uns ? (st.acc > U16_MAX)
                  : (st.acc > I16_MAX + 64'(st.negative))) begin
            st.first_error = note_err(st.first_error, ERR_BIG);
          end
          ty = uns ? TY_WORD : TY_SHORT;
        end else if (st.width_suffix == 7'd32) begin
          if (uns ? (st.acc > U32_MAX)
                  : (st.acc > I32_MAX + 64'(st.negative))) begin
            st.first_error = note_err(st.first_error, ERR_BIG);
          end
          ty = uns ? TY_DWORD : TY_INT;
        end else begin
          st.first_error = note_err(st.first_error, ERR_INVALID);
          ty = uns ? TY_DWORD : TY_INT;
        end
      end
    end

    if (!done && st.phase == PH_L) begin
      done = 1'b1;
      if (is_alnum(ch_i)) st.first_error = note_err(st.first_error, ERR_INVALID);
      if (!st.flags.u) begin
        if (st.negative ? (st.acc > TOP_BIT) : (st.acc > I64_MAX)) begin
          st.first_error = note_err(st.first_error, ERR_BIG);
        end
      end
      ty  = st.flags.u ? TY_QWORD : TY_LONG;
      fin = 1'b1;
    end

    if (!done && st.phase == PH_P) begin
      ty  = TY_PTR;
      fin = 1'b1;
    end

    // Range checks common to every finished literal.
    if (fin) begin
      emit = 1'b1;
      if (st.flags.u || st.flags.p) begin
        if (st.negative) st.first_error = note_err(st.first_error, ERR_UMINUS);
        if (st.acc > U32_MAX && !st.flags.l) begin
          st.first_error = note_err(st.first_error, ERR_QWORD);
        end
      end else if (st.acc > (st.negative ? I32_NMAX : I32_MAX) && !st.flags.l) begin
        st.first_error = note_err(st.first_error, ERR_LONG);
      end
    end

    if (emit) st.phase = PH_IDLE;
  end

  assign cnt_ext             = CW'(cnt);
  assign result_o.value      = st.negative ? (64'd0 - st.acc) : st.acc;
  assign result_o.type_code  = ty;
  assign result_o.error_code = st.first_error;
  assign result_o.base_code  = st.radix;
  assign result_o.length     = (cnt_ext > CW'(8'hFF)) ? 8'hFF : cnt_ext[7:0];

  assign state_o = st;
  assign count_o = cnt;
  assign emit_o  = emit;

endmodule
`default_nettype wire

>>> hdl/ill_out_reg.sv
// Result register that holds one finished literal until the sink takes it.
`default_nettype none
module ill_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire ill_pkg::ill_result_t result_i,
  output logic               free_o,
  output logic               valid_o,
  input  wire logic          ready_i,
  output ill_pkg::ill_result_t result_o
);

  logic                 valid_q, valid_d;
  ill_pkg::ill_result_t result_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
`default_nettype wire

>>> hdl/integer_literal_lexer.sv
// Top level of the integer literal lexer: character stream in, literal records out.
//
//  Channel   Dir  Data                                   Sideband
//  s_axis    in   tdata[7:0] ch                          tuser[0] start_req
//  m_axis    out  tdata[87:0] value,type,error,base,len  none
//
// Each character transaction is captured in an input register and is lexed
// from there by one pass of combinational logic, one character per clock while
// the result register is free; the shift-add accumulator step sets the longest
// path. The record of a literal is registered as its last character is lexed.
// Reset returns the lexer to idle with no pending literal and empties both
// registers. A stalled result register holds the lexer, and the input side
// then accepts at most the one character that the input register can hold.
`default_nettype none
module integer_literal_lexer #(
  parameter int unsigned LEN_BITS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  wire logic [0:0]  s_axis_tuser,   // [0] start_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [63:0] value, [67:64] type_code, [70:68] error_code, [72:71] base_code,
  // [80:73] length, [87:81] zero
  output logic [87:0]      m_axis_tdata
);
  import ill_pkg::*;

  // Held character waiting for the lexer.
  logic       in_valid;
  logic [7:0] in_ch;
  logic       in_start;
  logic       fire;

  // Lexer state across characters of one literal.
  ill_state_t          state_q, state_d;
  logic [LEN_BITS-1:0] count_q, count_d;

  logic        emit;
  ill_result_t result;
  logic        out_free;
  ill_result_t out_result;

  ill_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .ch_i    (s_axis_tdata),
    .start_i (s_axis_tuser[0]),
    .take_i  (fire),
    .valid_o (in_valid),
    .ch_o    (in_ch),
    .start_o (in_start)
  );

  ill_step #(
    .LEN_BITS (LEN_BITS)
  ) u_step (
    .state_i  (state_q),
    .count_i  (count_q),
    .ch_i     (in_ch),
    .start_i  (in_start),
    .state_o  (state_d),
    .count_o  (count_d),
    .emit_o   (emit),
    .result_o (result)
  );

  // A character is lexed only when the result register could take a record,
  // whether or not this character actually finishes a literal.
  assign fire = in_valid && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase        <= PH_IDLE;
      state_q.acc          <= '0;
      state_q.radix        <= BASE_DEC;
      state_q.negative     <= 1'b0;
      state_q.width_suffix <= '0;
      state_q.flags        <= '0;
      state_q.first_error  <= ERR_OK;
      count_q              <= '0;
    end else if (fire) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  ill_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && emit),
    .result_i (result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = {7'd0, out_result};

endmodule
`default_nettype wire
